// File: sv/sgdm_pkg.sv
package sgdm_pkg;

    // Data values are signed fixed point; coefficients are unsigned with COEF_FRAC
    // fraction bits and one integer bit so that 1.0 can be represented.
    localparam int DATA_WIDTH = 32;
    localparam int COEF_FRAC  = 24;
    localparam int COEF_WIDTH = COEF_FRAC + 1;
    localparam int PROD_WIDTH = DATA_WIDTH + COEF_WIDTH;
    localparam int RND_WIDTH  = PROD_WIDTH + 1 - COEF_FRAC;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [COEF_WIDTH-1:0]        coef_t;

    localparam coef_t COEF_ONE = coef_t'(1) << COEF_FRAC;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEARN_RATE = 3'd0,
        REG_MOMENTUM   = 3'd1,
        REG_DAMPENING  = 3'd2,
        REG_DECAY      = 3'd3,
        REG_NESTEROV   = 3'd4
    } cfg_idx_t;

    // Configuration as seen by the datapath. keep is (1 - dampening), clamped at zero.
    typedef struct packed {
        coef_t learn_rate;
        coef_t momentum;
        coef_t keep;
        coef_t decay;
        logic  mom_on;
        logic  nesterov;
    } cfg_t;

    // Signed add that saturates to the data range.
    function automatic data_t sat_add(data_t a, data_t b);
        logic signed [DATA_WIDTH:0] s;
        data_t                      r;
        begin
            s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
            if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
            begin
                r = s[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                  : {1'b0, {(DATA_WIDTH-1){1'b1}}};
            end
            else
            begin
                r = s[DATA_WIDTH-1:0];
            end
            return r;
        end
    endfunction

endpackage

// File: sv/sgdm_cfg_regs.sv
module sgdm_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sgdm_pkg::COEF_WIDTH-1:0] cfg_data,
    output sgdm_pkg::cfg_t                 cfg
);

    localparam sgdm_pkg::coef_t LR_RESET = sgdm_pkg::COEF_WIDTH'(167772);

    sgdm_pkg::coef_t lr_reg;
    sgdm_pkg::coef_t mom_reg;
    sgdm_pkg::coef_t damp_reg;
    sgdm_pkg::coef_t decay_reg;
    logic            nest_reg;

    // Writes are always taken; indexes past the register list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg    <= LR_RESET;
            mom_reg   <= '0;
            damp_reg  <= '0;
            decay_reg <= '0;
            nest_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sgdm_pkg::cfg_idx_t'(cfg_index))
                sgdm_pkg::REG_LEARN_RATE: lr_reg    <= {1'b0, cfg_data[sgdm_pkg::COEF_FRAC-1:0]};
                sgdm_pkg::REG_MOMENTUM:   mom_reg   <= {1'b0, cfg_data[sgdm_pkg::COEF_FRAC-1:0]};
                sgdm_pkg::REG_DAMPENING:  damp_reg  <= cfg_data;
                sgdm_pkg::REG_DECAY:      decay_reg <= {1'b0, cfg_data[sgdm_pkg::COEF_FRAC-1:0]};
                sgdm_pkg::REG_NESTEROV:   nest_reg  <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        cfg.learn_rate = lr_reg;
        cfg.momentum   = mom_reg;
        cfg.keep       = (damp_reg >= sgdm_pkg::COEF_ONE) ? '0 : sgdm_pkg::COEF_ONE - damp_reg;
        cfg.decay      = decay_reg;
        cfg.mom_on     = (mom_reg != '0);
        cfg.nesterov   = nest_reg;
    end

endmodule

// File: sv/sgdm_coef_mul.sv
module sgdm_coef_mul
(
    input  logic                  clk,
    input  logic                  en,
    input  sgdm_pkg::data_t       a,
    input  sgdm_pkg::coef_t       coef,
    input  logic                  flip,
    output sgdm_pkg::data_t       p
);

    localparam int DW = sgdm_pkg::DATA_WIDTH;
    localparam int PW = sgdm_pkg::PROD_WIDTH;
    localparam int RW = sgdm_pkg::RND_WIDTH;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (sgdm_pkg::COEF_FRAC - 1);

    logic [PW-1:0]   prod_reg;
    logic [PW-1:0]   prod_next;
    logic            neg_reg;
    logic            neg_next;
    sgdm_pkg::data_t p_reg;
    sgdm_pkg::data_t p_next;

    logic [DW-1:0]   mag;
    logic [PW:0]     rsum;
    logic [RW-1:0]   rnd;
    logic [DW-1:0]   limit;
    logic [DW-1:0]   sat;

    // First cycle: magnitude times coefficient at full precision.
    always_comb
    begin
        mag       = a[DW-1] ? (~$unsigned(a) + 1'b1) : $unsigned(a);
        neg_next  = a[DW-1] ^ flip;
        prod_next = PW'(mag) * PW'(coef);
    end

    // Second cycle: round half away from zero, clamp the magnitude, restore the sign.
    always_comb
    begin
        rsum   = {1'b0, prod_reg} + HALF;
        rnd    = rsum[PW:sgdm_pkg::COEF_FRAC];
        limit  = neg_reg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        sat    = (rnd > RW'(limit)) ? limit : rnd[DW-1:0];
        p_next = neg_reg ? sgdm_pkg::data_t'(~sat + 1'b1) : sgdm_pkg::data_t'(sat);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: sv/sgd_momentum_update.sv
// SGD with momentum, one element per beat. One beat is accepted every cycle while
// the output is not stalled. Four dependent coefficient multiplies, each with a
// product register and an output register, plus a saturating add after each, set
// the pipeline depth. rst_n clears all valid bits and returns the configuration
// registers to their defaults; data registers hold.
module sgd_momentum_update
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgdm_pkg::COEF_WIDTH-1:0] cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [sgdm_pkg::DATA_WIDTH-1:0] weight_in,
    input  logic signed [sgdm_pkg::DATA_WIDTH-1:0] gradient,
    input  logic signed [sgdm_pkg::DATA_WIDTH-1:0] velocity_in,
    input  logic                            velocity_valid,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [sgdm_pkg::DATA_WIDTH-1:0] weight_out,
    output logic signed [sgdm_pkg::DATA_WIDTH-1:0] velocity_out
);

    localparam int DEPTH = 12;

    sgdm_pkg::cfg_t  cfg;

    // The whole pipe moves together. The last stage is the output register, so
    // a waiting result only blocks the pipe while the downstream side stalls it.
    logic            adv;

    logic [DEPTH:1]  vld_reg;

    // Side-band data that rides along with each beat. The index of each entry
    // is the number of the stage that holds it.
    sgdm_pkg::data_t w_pipe_reg  [1:11];
    sgdm_pkg::data_t g_pipe_reg  [1:2];
    sgdm_pkg::data_t v_pipe_reg  [1:3];
    logic            hv_pipe_reg [1:5];
    sgdm_pkg::data_t d_pipe_reg  [3:8];
    sgdm_pkg::data_t vn_pipe_reg [6:11];

    sgdm_pkg::data_t d_next;
    sgdm_pkg::data_t vn_next;
    sgdm_pkg::data_t step_reg;
    sgdm_pkg::data_t step_next;
    sgdm_pkg::data_t wout_reg;
    sgdm_pkg::data_t wout_next;
    sgdm_pkg::data_t vout_reg;

    // Multiplier results, taken from each multiplier's output register.
    sgdm_pkg::data_t p_decay;
    sgdm_pkg::data_t p_mom_v;
    sgdm_pkg::data_t p_keep_d;
    sgdm_pkg::data_t p_mom_vn;
    sgdm_pkg::data_t p_lr;

    assign adv      = !(vld_reg[DEPTH] && out_stall);
    assign in_stall = !adv;

    sgdm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stages 1-2: weight decay term, decay * w.
    sgdm_coef_mul u_mul_decay
    (
        .clk  (clk),
        .en   (adv),
        .a    (weight_in),
        .coef (cfg.decay),
        .flip (1'b0),
        .p    (p_decay)
    );

    // Stages 4-5: both halves of the velocity update run side by side.
    sgdm_coef_mul u_mul_mom_v
    (
        .clk  (clk),
        .en   (adv),
        .a    (v_pipe_reg[3]),
        .coef (cfg.momentum),
        .flip (1'b0),
        .p    (p_mom_v)
    );

    sgdm_coef_mul u_mul_keep_d
    (
        .clk  (clk),
        .en   (adv),
        .a    (d_pipe_reg[3]),
        .coef (cfg.keep),
        .flip (1'b0),
        .p    (p_keep_d)
    );

    // Stages 7-8: Nesterov lookahead, momentum * v'.
    sgdm_coef_mul u_mul_mom_vn
    (
        .clk  (clk),
        .en   (adv),
        .a    (vn_pipe_reg[6]),
        .coef (cfg.momentum),
        .flip (1'b0),
        .p    (p_mom_vn)
    );

    // Stages 10-11: the negated learning-rate step, so stage 12 only adds.
    sgdm_coef_mul u_mul_lr
    (
        .clk  (clk),
        .en   (adv),
        .a    (step_reg),
        .coef (cfg.learn_rate),
        .flip (1'b1),
        .p    (p_lr)
    );

    always_comb
    begin
        // Stage 3: gradient plus decay.
        d_next = sgdm_pkg::sat_add(g_pipe_reg[2], p_decay);

        // Stage 6: new velocity. Without momentum there is no velocity at all;
        // on the first step for an element the velocity starts at d.
        if (!cfg.mom_on)
        begin
            vn_next = '0;
        end
        else if (!hv_pipe_reg[5])
        begin
            vn_next = d_pipe_reg[5];
        end
        else
        begin
            vn_next = sgdm_pkg::sat_add(p_mom_v, p_keep_d);
        end

        // Stage 9: step direction.
        if (!cfg.mom_on)
        begin
            step_next = d_pipe_reg[8];
        end
        else if (cfg.nesterov)
        begin
            step_next = sgdm_pkg::sat_add(d_pipe_reg[8], p_mom_vn);
        end
        else
        begin
            step_next = vn_pipe_reg[8];
        end

        // Stage 12: weight update.
        wout_next = sgdm_pkg::sat_add(w_pipe_reg[11], p_lr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_pipe_reg[1]  <= weight_in;
            g_pipe_reg[1]  <= gradient;
            v_pipe_reg[1]  <= velocity_in;
            hv_pipe_reg[1] <= velocity_valid;
            for (int k = 2; k <= 11; k++)
            begin
                w_pipe_reg[k] <= w_pipe_reg[k-1];
            end
            g_pipe_reg[2] <= g_pipe_reg[1];
            v_pipe_reg[2] <= v_pipe_reg[1];
            v_pipe_reg[3] <= v_pipe_reg[2];
            for (int k = 2; k <= 5; k++)
            begin
                hv_pipe_reg[k] <= hv_pipe_reg[k-1];
            end
            d_pipe_reg[3] <= d_next;
            for (int k = 4; k <= 8; k++)
            begin
                d_pipe_reg[k] <= d_pipe_reg[k-1];
            end
            vn_pipe_reg[6] <= vn_next;
            for (int k = 7; k <= 11; k++)
            begin
                vn_pipe_reg[k] <= vn_pipe_reg[k-1];
            end
            step_reg <= step_next;
            wout_reg <= wout_next;
            vout_reg <= vn_pipe_reg[11];
        end
    end

    assign out_valid    = vld_reg[DEPTH];
    assign weight_out   = wout_reg;
    assign velocity_out = vout_reg;

`ifndef SYNTHESIS
    // A held pipe keeps every beat where it is.
    a_hold_keeps_beats: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved while the output was stalled");

    // With momentum off no velocity is ever produced.
    a_no_velocity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !cfg.mom_on) |-> (velocity_out == '0))
        else $error("velocity produced with momentum disabled");

    // A beat reaching the output means one entered the pipe DEPTH moves earlier.
    a_no_invented_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !vld_reg[DEPTH-1]) |=> !out_valid)
        else $error("output beat appeared without a matching input beat");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the SGD momentum update block.
//
// A short directed table runs first. It covers the field extremes, momentum
// off, dampening of exactly one and above one, Nesterov with and without
// momentum, and rounding of ties away from zero. After that come randomized
// phases, each with its own register setting. A local predictor of the update
// arithmetic handles every accepted input beat without a typed-in result. The
// scoreboard compares each accepted output beat against the oldest prediction.
module tb_top;

    localparam sgdm_pkg::data_t DATA_MAX = 32'sh7FFF_FFFF;
    localparam sgdm_pkg::data_t DATA_MIN = 32'sh8000_0000;
    localparam sgdm_pkg::data_t Q_ONE    = 32'sh0100_0000;

    localparam longint LIM_HI = 64'sd2147483647;
    localparam longint LIM_LO = -64'sd2147483648;

    // Index past the last register; a write there must change nothing.
    localparam logic [sgdm_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int RANDOM_PHASES    = 10;
    localparam int ITEMS_PER_PHASE  = 65;
    localparam int DRAIN_CYCLES     = 30;
    localparam int REPORT_LIMIT     = 10;

    typedef struct {
        sgdm_pkg::data_t w;
        sgdm_pkg::data_t v;
    } update_t;

    // Raw write values; the register keeps only its own width.
    typedef struct {
        sgdm_pkg::coef_t rate;
        sgdm_pkg::coef_t mom;
        sgdm_pkg::coef_t damp;
        sgdm_pkg::coef_t decay;
        sgdm_pkg::coef_t nest;
    } settings_t;

    // One directed row. When known is set, the expected update is typed in
    // here; otherwise it comes from the predictor.
    typedef struct {
        int              sel;
        sgdm_pkg::data_t w;
        sgdm_pkg::data_t g;
        sgdm_pkg::data_t v;
        logic            vv;
        bit              known;
        sgdm_pkg::data_t ew;
        sgdm_pkg::data_t ev;
    } directed_row_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;

    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sgdm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    sgdm_pkg::coef_t                cfg_data = '0;

    logic            in_valid = 1'b0;
    logic            in_stall;
    sgdm_pkg::data_t weight_in = '0;
    sgdm_pkg::data_t gradient = '0;
    sgdm_pkg::data_t velocity_in = '0;
    logic            velocity_valid = 1'b0;

    logic            out_valid;
    logic            out_stall = 1'b0;
    sgdm_pkg::data_t weight_out;
    sgdm_pkg::data_t velocity_out;

    // Local copy of the register file, updated when a write is accepted.
    sgdm_pkg::coef_t rate_q;
    sgdm_pkg::coef_t mom_q;
    sgdm_pkg::coef_t damp_q;
    sgdm_pkg::coef_t decay_q;
    logic            nest_q;

    update_t pending_updates[$];
    int      mismatch_count = 0;
    int      burst_left = 0;
    int      stall_mode = 0;
    int      stall_left = 0;

    sgd_momentum_update dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .weight_in      (weight_in),
        .gradient       (gradient),
        .velocity_in    (velocity_in),
        .velocity_valid (velocity_valid),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .weight_out     (weight_out),
        .velocity_out   (velocity_out)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor of the update arithmetic.
    // ------------------------------------------------------------------

    function automatic longint clamp_data(longint x);
        if (x > LIM_HI)
        begin
            return LIM_HI;
        end
        if (x < LIM_LO)
        begin
            return LIM_LO;
        end
        return x;
    endfunction

    // Both operands are already within the data range, so the 64-bit sum
    // cannot wrap.
    function automatic longint add_clamped(longint a, longint b);
        return clamp_data(a + b);
    endfunction

    // round(a * c / 2^24), ties away from zero, optionally negated, then
    // saturated. Rounding works on the magnitude, so it is symmetric.
    function automatic longint scale_round(longint a, sgdm_pkg::coef_t c, bit flip);
        bit               neg;
        longint unsigned  mag;
        longint unsigned  r;
        longint unsigned  lim;
        neg = (a < 0) ^ flip;
        mag = (a < 0) ? longint'(-a) : a;
        r   = (mag * c + 64'h0080_0000) >> sgdm_pkg::COEF_FRAC;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (r > lim)
        begin
            r = lim;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic update_t predict_update(sgdm_pkg::data_t w_in,
                                               sgdm_pkg::data_t g_in,
                                               sgdm_pkg::data_t v_in,
                                               logic have_v);
        longint          w;
        longint          d;
        longint          stp;
        longint          vn;
        sgdm_pkg::coef_t keep;
        update_t         res;
        w  = longint'(w_in);
        d  = add_clamped(longint'(g_in), scale_round(w, decay_q, 1'b0));
        stp = d;
        vn = 0;
        if (mom_q != '0)
        begin
            if (!have_v)
            begin
                vn = d;
            end
            else
            begin
                // A dampening of one or more leaves none of the new gradient.
                keep = (damp_q >= sgdm_pkg::COEF_ONE) ? '0 : sgdm_pkg::COEF_ONE - damp_q;
                vn = add_clamped(scale_round(longint'(v_in), mom_q, 1'b0),
                                 scale_round(d, keep, 1'b0));
            end
            stp = nest_q ? add_clamped(d, scale_round(vn, mom_q, 1'b0)) : vn;
        end
        res.w = sgdm_pkg::data_t'(add_clamped(w, scale_round(stp, rate_q, 1'b1)));
        res.v = sgdm_pkg::data_t'(vn);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random value sources.
    // ------------------------------------------------------------------

    // Mix of extremes, tiny values and values of every magnitude, so that
    // both the saturating and the exact paths see plenty of traffic.
    function automatic sgdm_pkg::data_t rand_data();
        sgdm_pkg::data_t x;
        case ($urandom_range(0, 9))
            0: x = DATA_MAX;
            1: x = DATA_MIN;
            2: x = '0;
            3: x = sgdm_pkg::data_t'($urandom_range(0, 8)) - 32'sd4;
            default:
            begin
                x = sgdm_pkg::data_t'($urandom);
                x = x >>> $urandom_range(0, 28);
            end
        endcase
        return x;
    endfunction

    function automatic sgdm_pkg::coef_t rand_coef();
        sgdm_pkg::coef_t c;
        case ($urandom_range(0, 6))
            0: c = '0;
            1: c = 25'h0FF_FFFF;
            2: c = 25'h1FF_FFFF;
            3: c = 25'h080_0000;
            4: c = sgdm_pkg::coef_t'($urandom);
            5: c = sgdm_pkg::coef_t'($urandom_range(0, 32'h0010_0000));
            default: c = sgdm_pkg::coef_t'($urandom_range(0, 32'h00FF_FFFF));
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes. Each task is entered just after a falling edge
    // and returns just after one.
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [sgdm_pkg::CFG_IDX_W-1:0] idx,
                             input sgdm_pkg::coef_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            sgdm_pkg::REG_LEARN_RATE: rate_q  = {1'b0, value[sgdm_pkg::COEF_FRAC-1:0]};
            sgdm_pkg::REG_MOMENTUM:   mom_q   = {1'b0, value[sgdm_pkg::COEF_FRAC-1:0]};
            sgdm_pkg::REG_DAMPENING:  damp_q  = value;
            sgdm_pkg::REG_DECAY:      decay_q = {1'b0, value[sgdm_pkg::COEF_FRAC-1:0]};
            sgdm_pkg::REG_NESTEROV:   nest_q  = value[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Valid stays high across back-to-back writes and drops after the last.
    task automatic apply_settings(input settings_t s, input bit with_spare);
        write_reg(sgdm_pkg::REG_LEARN_RATE, s.rate);
        write_reg(sgdm_pkg::REG_MOMENTUM, s.mom);
        write_reg(sgdm_pkg::REG_DAMPENING, s.damp);
        write_reg(sgdm_pkg::REG_DECAY, s.decay);
        write_reg(sgdm_pkg::REG_NESTEROV, s.nest);
        if (with_spare)
        begin
            write_reg(REG_SPARE, 25'h1FF_FFFF);
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Input side. The sender runs in bursts of random length, and random
    // gaps fall between them. Valid never looks at stall, and a stalled beat
    // holds its payload.
    // ------------------------------------------------------------------

    task automatic send_update(input sgdm_pkg::data_t w, input sgdm_pkg::data_t g,
                               input sgdm_pkg::data_t v, input logic vv,
                               input bit known, input sgdm_pkg::data_t ew,
                               input sgdm_pkg::data_t ev);
        update_t res;
        int      gap;
        in_valid       <= 1'b1;
        weight_in      <= w;
        gradient       <= g;
        velocity_in    <= v;
        velocity_valid <= vv;
        do
            @(posedge clk);
        while (in_stall);
        if (known)
        begin
            res.w = ew;
            res.v = ev;
        end
        else
        begin
            res = predict_update(w, g, v, vv);
        end
        pending_updates.push_back(res);
        @(negedge clk);
        if (burst_left == 0)
        begin
            // Idle beats carry junk payload, which the block must ignore.
            in_valid       <= 1'b0;
            weight_in      <= sgdm_pkg::data_t'($urandom);
            gradient       <= sgdm_pkg::data_t'($urandom);
            velocity_in    <= sgdm_pkg::data_t'($urandom);
            velocity_valid <= 1'($urandom_range(0, 1));
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(0, 40);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Registers change only with the pipeline empty. Each input makes
    // exactly one result, so an empty scoreboard means nothing is in flight.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_updates.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side. The receiver stalls on a pattern of its own: open stretches,
    // random stalls, mostly stalled stretches and solid stalls that then open.
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(4, 50);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_left > 20);
        endcase
    end

    // Scoreboard: each accepted output beat against the oldest prediction.
    always @(posedge clk)
    begin
        update_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_updates.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("unexpected output beat: weight_out=%0d velocity_out=%0d",
                             weight_out, velocity_out);
                end
            end
            else
            begin
                want = pending_updates.pop_front();
                if (want.w !== weight_out || want.v !== velocity_out)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display({"mismatch: weight_out exp %0d got %0d, ",
                                  "velocity_out exp %0d got %0d"},
                                 want.w, weight_out, want.v, velocity_out);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------

    initial
    begin
        directed_row_t directed_rows[$];
        settings_t     directed_sets[$];
        directed_row_t r;
        settings_t     s;
        int            cur_sel;

        // Register values that reset is expected to load.
        rate_q  = 25'd167772;
        mom_q   = '0;
        damp_q  = '0;
        decay_q = '0;
        nest_q  = 1'b0;

        // Setting 0 is the reset state and is never written. Setting 1 puts
        // rate, momentum and decay at their top, with the extra bit set to show
        // that 24-bit registers drop it; its dampening is zero. Setting 2 has
        // dampening exactly one and a half-step rate for ties. Setting 3 has
        // dampening above one. Setting 4 is Nesterov with momentum off.
        // Setting 5 is Nesterov combined with dampening.
        directed_sets.push_back('{25'd167772, 25'd0, 25'd0, 25'd0, 25'd0});
        directed_sets.push_back('{25'h1FF_FFFF, 25'h1FF_FFFF, 25'd0, 25'h1FF_FFFF, 25'd1});
        directed_sets.push_back('{25'h080_0000, 25'h080_0000, 25'h100_0000, 25'd0, 25'd0});
        directed_sets.push_back('{25'd0, 25'h040_0000, 25'h1FF_FFFF, 25'd0, 25'd1});
        directed_sets.push_back('{25'h040_0000, 25'd0, 25'h012_3456, 25'h010_0000, 25'd1});
        directed_sets.push_back('{25'h020_0000, 25'h060_0000, 25'h030_0000, 25'h001_0000,
                                  25'd1});

        // Reset state: rate about 0.01, momentum off, velocity ignored.
        directed_rows.push_back('{0, 0, 0, 0, 1'b0, 1'b1, 0, 0});
        directed_rows.push_back('{0, DATA_MAX, 0, 0, 1'b0, 1'b1, DATA_MAX, 0});
        directed_rows.push_back('{0, DATA_MIN, 0, 0, 1'b0, 1'b1, DATA_MIN, 0});
        directed_rows.push_back('{0, DATA_MIN, DATA_MAX, 0, 1'b0, 1'b1, DATA_MIN, 0});
        directed_rows.push_back('{0, DATA_MAX, DATA_MIN, 0, 1'b0, 1'b1, DATA_MAX, 0});
        directed_rows.push_back('{0, 0, 0, DATA_MAX, 1'b1, 1'b1, 0, 0});
        directed_rows.push_back('{0, Q_ONE, DATA_MAX, DATA_MIN, 1'b1, 1'b0, 0, 0});
        directed_rows.push_back('{0, 0, Q_ONE, 0, 1'b0, 1'b0, 0, 0});
        // Rate, momentum and decay at their top.
        directed_rows.push_back('{1, 0, 0, 0, 1'b0, 1'b1, 0, 0});
        directed_rows.push_back('{1, DATA_MAX, DATA_MAX, DATA_MAX, 1'b1, 1'b0, 0, 0});
        directed_rows.push_back('{1, DATA_MIN, DATA_MIN, DATA_MIN, 1'b1, 1'b0, 0, 0});
        directed_rows.push_back('{1, Q_ONE, -Q_ONE, Q_ONE, 1'b0, 1'b0, 0, 0});
        directed_rows.push_back('{1, -Q_ONE, 0, DATA_MIN, 1'b1, 1'b0, 0, 0});
        // Half-step rate: a step of one LSB rounds away from zero.
        directed_rows.push_back('{2, 10, 1, 0, 1'b0, 1'b1, 9, 1});
        directed_rows.push_back('{2, 10, -1, 0, 1'b0, 1'b1, 11, -1});
        directed_rows.push_back('{2, 0, 0, Q_ONE, 1'b1, 1'b1, -32'sh0040_0000,
                                  32'sh0080_0000});
        directed_rows.push_back('{2, 0, DATA_MAX, 3, 1'b1, 1'b0, 0, 0});
        directed_rows.push_back('{2, 0, 0, -3, 1'b1, 1'b0, 0, 0});
        // Zero rate, dampening above one.
        directed_rows.push_back('{3, 5, Q_ONE, 0, 1'b0, 1'b1, 5, Q_ONE});
        directed_rows.push_back('{3, 5, DATA_MAX, Q_ONE, 1'b1, 1'b1, 5, 32'sh0040_0000});
        directed_rows.push_back('{3, DATA_MIN, DATA_MIN, DATA_MIN, 1'b1, 1'b0, 0, 0});
        // Nesterov with momentum off.
        directed_rows.push_back('{4, Q_ONE, Q_ONE, DATA_MAX, 1'b1, 1'b0, 0, 0});
        directed_rows.push_back('{4, DATA_MIN, DATA_MAX, 0, 1'b0, 1'b0, 0, 0});
        // Nesterov with dampening.
        directed_rows.push_back('{5, Q_ONE, -Q_ONE, Q_ONE, 1'b1, 1'b0, 0, 0});
        directed_rows.push_back('{5, DATA_MAX, DATA_MAX, DATA_MAX, 1'b0, 1'b0, 0, 0});
        directed_rows.push_back('{5, 0, 0, 0, 1'b0, 1'b1, 0, 0});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        cur_sel = 0;
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.sel != cur_sel)
            begin
                drain_pipeline();
                // The spare index is written once, along with the first setting.
                apply_settings(directed_sets[r.sel], cur_sel == 0);
                cur_sel = r.sel;
            end
            send_update(r.w, r.g, r.v, r.vv, r.known, r.ew, r.ev);
        end

        // Random phases. Each one picks a fresh setting. Dampening of exactly
        // one is favored, since it is a boundary of the clamp.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_pipeline();
            s.rate  = rand_coef();
            s.mom   = rand_coef();
            s.damp  = ($urandom_range(0, 3) == 0) ? 25'h100_0000 : rand_coef();
            s.decay = rand_coef();
            s.nest  = sgdm_pkg::coef_t'($urandom);
            apply_settings(s, 1'b0);
            repeat (ITEMS_PER_PHASE)
            begin
                send_update(rand_data(), rand_data(), rand_data(),
                            1'($urandom_range(0, 1)), 1'b0, 0, 0);
            end
        end

        drain_pipeline();
        // Any further beat that trails out of the pipeline is caught here.
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && pending_updates.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog. This is far longer than the slowest correct run, which is
    // all long gaps and solid stalls.
    initial
    begin
        #800000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sgd_momentum_update.f
sv/sgdm_pkg.sv
sv/sgdm_cfg_regs.sv
sv/sgdm_coef_mul.sv
sv/sgd_momentum_update.sv
test/tb_top.sv
